@@ sv/union_find_percolation_tracker_macros.svh @@
// Assertion helpers shared by the checker.
`ifndef UNION_FIND_PERCOLATION_TRACKER_MACROS_SVH
`define UNION_FIND_PERCOLATION_TRACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UFPT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ufpt check failed");

// Next-cycle implication, disabled while reset is asserted.
`define UFPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ufpt check failed");

`endif

@@ sv/ufpt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ufpt_pkg;
    localparam int NODES  = 1024;
    localparam int ADDR_W = $clog2(NODES);
    localparam int NODE_W = 10;
    localparam int SIZE_W = 11;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_LINK  = 2'd2;

    typedef struct packed {
        logic              present;
        logic              is_root;
        logic [NODE_W-1:0] parent;
        logic [SIZE_W-1:0] size;
    } entry_t;
endpackage
`default_nettype wire

@@ sv/ufpt_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ufpt_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 23
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

@@ sv/union_find_percolation_tracker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Union-find percolation tracker. An item is accepted when start is high and
// busy is low; action selects clear, add node, offer a link of the current
// source node, or no-op. Every item gives exactly one result, shown for one
// cycle with result_strobe high. The receiver cannot stall, so results are
// never held. Finding a root follows the parent pointers one hop at a time,
// and path compression then rewrites each node of the walked path to point
// at the root; a merging link adds the root lookups plus two writes. All
// node state lives in one single-port memory with a registered read, so each
// item makes its memory accesses one at a time, and a new item is not taken
// while one is in progress. A clear item writes every memory entry to zero
// and then gives its result. After reset the same clearing pass runs, with
// busy high, and gives no result. busy is high whenever an item is in
// progress.
module union_find_percolation_tracker
    import ufpt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        action,
    input  wire logic [NODE_W-1:0] node,
    input  wire logic [NODE_W-1:0] neighbor,
    input  wire logic              link_active,
    input  wire logic              last_link,
    output logic                   result_strobe,
    output logic [SIZE_W-1:0]      cluster_size,
    output logic [SIZE_W-1:0]      component_count,
    output logic [SIZE_W-1:0]      largest_size,
    output logic [NODE_W-1:0]      largest_root,
    output logic                   merged,
    output logic                   node_done
);
    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_NOP, S_ARD, S_LRD, S_NRD,
        S_FIND, S_COMP, S_CRD, S_FOUND, S_M2
    } state_t;

    state_t            state_reg, state_next;
    logic [1:0]        action_reg, action_next;
    logic [NODE_W-1:0] nb_reg, nb_next;
    logic              active_reg, active_next;
    logic              last_reg, last_next;
    logic [NODE_W-1:0] cur_reg, cur_next;
    logic [NODE_W-1:0] start_reg, start_next;
    logic [NODE_W-1:0] root_reg, root_next;
    logic [NODE_W-1:0] nxt_reg, nxt_next;
    entry_t            root_e_reg, root_e_next;
    entry_t            s_e_reg, s_e_next;
    logic [SIZE_W-1:0] sum_reg, sum_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic              clr_item_reg, clr_item_next;
    logic [NODE_W-1:0] src_reg, src_next;
    logic [SIZE_W-1:0] comps_reg, comps_next;
    logic [SIZE_W-1:0] lg_size_reg, lg_size_next;
    logic [NODE_W-1:0] lg_root_reg, lg_root_next;
    logic              strobe_reg, strobe_next;
    logic [SIZE_W-1:0] o_size_reg, o_size_next;
    logic              o_merged_reg, o_merged_next;
    logic              o_done_reg, o_done_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    entry_t            mem_wdata;
    entry_t            rdata;

    logic              do_find;
    logic              fin;
    logic              fin_track;
    logic              fin_merged;
    logic [SIZE_W-1:0] fin_size;

    ufpt_ram #(
        .DEPTH (NODES),
        .WIDTH ($bits(entry_t))
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        action_next   = action_reg;
        nb_next       = nb_reg;
        active_next   = active_reg;
        last_next     = last_reg;
        cur_next      = cur_reg;
        start_next    = start_reg;
        root_next     = root_reg;
        nxt_next      = nxt_reg;
        root_e_next   = root_e_reg;
        s_e_next      = s_e_reg;
        sum_next      = sum_reg;
        cnt_next      = cnt_reg;
        clr_item_next = clr_item_reg;
        src_next      = src_reg;
        comps_next    = comps_reg;
        lg_size_next  = lg_size_reg;
        lg_root_next  = lg_root_reg;
        strobe_next   = 1'b0;
        o_size_next   = o_size_reg;
        o_merged_next = o_merged_reg;
        o_done_next   = o_done_reg;
        mem_we        = 1'b0;
        mem_addr      = ADDR_W'(cur_reg);
        mem_wdata     = '0;
        do_find       = 1'b0;
        fin           = 1'b0;
        fin_track     = 1'b0;
        fin_merged    = 1'b0;
        fin_size      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    action_next = action;
                    nb_next     = neighbor;
                    active_next = link_active;
                    last_next   = last_link;
                    case (action)
                        ACT_CLEAR:
                        begin
                            src_next      = '0;
                            comps_next    = '0;
                            lg_size_next  = '0;
                            lg_root_next  = '0;
                            cnt_next      = '0;
                            clr_item_next = 1'b1;
                            state_next    = S_CLR;
                        end
                        ACT_ADD:
                        begin
                            mem_addr   = ADDR_W'(node);
                            cur_next   = node;
                            start_next = node;
                            state_next = S_ARD;
                        end
                        ACT_LINK:
                        begin
                            mem_addr   = ADDR_W'(src_reg);
                            state_next = S_LRD;
                        end
                        default:
                        begin
                            state_next = S_NOP;
                        end
                    endcase
                end
            end
            S_CLR:
            begin
                mem_we    = 1'b1;
                mem_addr  = cnt_reg;
                mem_wdata = '0;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == ADDR_W'(NODES - 1))
                begin
                    state_next = S_IDLE;
                    fin        = clr_item_reg;
                end
            end
            S_NOP:
            begin
                fin = 1'b1;
            end
            S_ARD:
            begin
                if (rdata.present)
                begin
                    do_find = 1'b1;
                end
                else
                begin
                    mem_we            = 1'b1;
                    mem_addr          = ADDR_W'(cur_reg);
                    mem_wdata.present = 1'b1;
                    mem_wdata.is_root = 1'b1;
                    mem_wdata.parent  = cur_reg;
                    mem_wdata.size    = SIZE_W'(1);
                    comps_next        = comps_reg + 1'b1;
                    src_next          = cur_reg;
                    fin               = 1'b1;
                    fin_track         = 1'b1;
                    fin_size          = SIZE_W'(1);
                end
            end
            S_LRD:
            begin
                s_e_next = rdata;
                if (!(rdata.present && rdata.is_root))
                begin
                    fin = 1'b1;
                end
                else if (active_reg)
                begin
                    mem_addr   = ADDR_W'(nb_reg);
                    cur_next   = nb_reg;
                    start_next = nb_reg;
                    state_next = S_NRD;
                end
                else
                begin
                    fin       = 1'b1;
                    fin_track = 1'b1;
                    fin_size  = rdata.size;
                end
            end
            S_NRD:
            begin
                if (rdata.present)
                begin
                    do_find = 1'b1;
                end
                else
                begin
                    fin       = 1'b1;
                    fin_track = 1'b1;
                    fin_size  = s_e_reg.size;
                end
            end
            S_FIND:
            begin
                do_find = 1'b1;
            end
            S_COMP:
            begin
                // Point this node of the walked path straight at the root.
                mem_we           = 1'b1;
                mem_addr         = ADDR_W'(cur_reg);
                mem_wdata        = rdata;
                mem_wdata.parent = root_reg;
                if (rdata.parent == root_reg)
                begin
                    state_next = S_FOUND;
                end
                else
                begin
                    nxt_next   = rdata.parent;
                    state_next = S_CRD;
                end
            end
            S_CRD:
            begin
                mem_addr   = ADDR_W'(nxt_reg);
                cur_next   = nxt_reg;
                state_next = S_COMP;
            end
            S_FOUND:
            begin
                if (action_reg == ACT_ADD)
                begin
                    src_next  = root_reg;
                    fin       = 1'b1;
                    fin_track = 1'b1;
                    fin_size  = root_e_reg.size;
                end
                else if (root_reg == src_reg)
                begin
                    fin       = 1'b1;
                    fin_track = 1'b1;
                    fin_size  = s_e_reg.size;
                end
                else
                begin
                    // The larger root wins; on a tie the source root wins.
                    sum_next   = s_e_reg.size + root_e_reg.size;
                    mem_we     = 1'b1;
                    state_next = S_M2;
                    if (s_e_reg.size < root_e_reg.size)
                    begin
                        mem_addr       = ADDR_W'(root_reg);
                        mem_wdata      = root_e_reg;
                        mem_wdata.size = sum_next;
                        nxt_next       = src_reg;
                        root_e_next    = s_e_reg;
                        src_next       = root_reg;
                    end
                    else
                    begin
                        mem_addr       = ADDR_W'(src_reg);
                        mem_wdata      = s_e_reg;
                        mem_wdata.size = sum_next;
                        nxt_next       = root_reg;
                    end
                end
            end
            S_M2:
            begin
                mem_we            = 1'b1;
                mem_addr          = ADDR_W'(nxt_reg);
                mem_wdata         = root_e_reg;
                mem_wdata.is_root = 1'b0;
                mem_wdata.parent  = src_reg;
                if (comps_reg != '0)
                begin
                    comps_next = comps_reg - 1'b1;
                end
                fin        = 1'b1;
                fin_track  = 1'b1;
                fin_merged = 1'b1;
                fin_size   = sum_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_find)
        begin
            if (rdata.is_root)
            begin
                root_next   = cur_reg;
                root_e_next = rdata;
                if (cur_reg == start_reg)
                begin
                    state_next = S_FOUND;
                end
                else
                begin
                    mem_addr   = ADDR_W'(start_reg);
                    cur_next   = start_reg;
                    state_next = S_COMP;
                end
            end
            else
            begin
                mem_addr   = ADDR_W'(rdata.parent);
                cur_next   = rdata.parent;
                state_next = S_FIND;
            end
        end

        if (fin)
        begin
            state_next    = S_IDLE;
            strobe_next   = 1'b1;
            o_size_next   = fin_size;
            o_merged_next = fin_merged;
            o_done_next   = last_reg && (action_reg != ACT_CLEAR);
            if (fin_track && (fin_size > lg_size_reg))
            begin
                lg_size_next = fin_size;
                lg_root_next = src_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            action_reg   <= ACT_CLEAR;
            nb_reg       <= '0;
            active_reg   <= 1'b0;
            last_reg     <= 1'b0;
            cur_reg      <= '0;
            start_reg    <= '0;
            root_reg     <= '0;
            nxt_reg      <= '0;
            root_e_reg   <= '0;
            s_e_reg      <= '0;
            sum_reg      <= '0;
            cnt_reg      <= '0;
            clr_item_reg <= 1'b0;
            src_reg      <= '0;
            comps_reg    <= '0;
            lg_size_reg  <= '0;
            lg_root_reg  <= '0;
            strobe_reg   <= 1'b0;
            o_size_reg   <= '0;
            o_merged_reg <= 1'b0;
            o_done_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            action_reg   <= action_next;
            nb_reg       <= nb_next;
            active_reg   <= active_next;
            last_reg     <= last_next;
            cur_reg      <= cur_next;
            start_reg    <= start_next;
            root_reg     <= root_next;
            nxt_reg      <= nxt_next;
            root_e_reg   <= root_e_next;
            s_e_reg      <= s_e_next;
            sum_reg      <= sum_next;
            cnt_reg      <= cnt_next;
            clr_item_reg <= clr_item_next;
            src_reg      <= src_next;
            comps_reg    <= comps_next;
            lg_size_reg  <= lg_size_next;
            lg_root_reg  <= lg_root_next;
            strobe_reg   <= strobe_next;
            o_size_reg   <= o_size_next;
            o_merged_reg <= o_merged_next;
            o_done_reg   <= o_done_next;
        end
    end

    assign busy            = (state_reg != S_IDLE);
    assign result_strobe   = strobe_reg;
    assign cluster_size    = o_size_reg;
    assign component_count = comps_reg;
    assign largest_size    = lg_size_reg;
    assign largest_root    = lg_root_reg;
    assign merged          = o_merged_reg;
    assign node_done       = o_done_reg;
endmodule
`default_nettype wire

@@ sv/ufpt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "union_find_percolation_tracker_macros.svh"
module ufpt_checker
    import ufpt_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              result_strobe,
    input wire logic [SIZE_W-1:0] cluster_size,
    input wire logic [SIZE_W-1:0] largest_size,
    input wire logic              merged
);
    // An accepted item always makes busy high in the cycle after it is accepted.
    `UFPT_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // The reported cluster never exceeds the largest recorded one.
    `UFPT_ASSERT_NOW(a_largest, clk, rst_n, result_strobe, largest_size >= cluster_size)
    // A merge joins two nonempty clusters.
    `UFPT_ASSERT_NOW(a_merge_size, clk, rst_n, result_strobe && merged,
        cluster_size >= SIZE_W'(2))
endmodule

bind union_find_percolation_tracker ufpt_checker u_ufpt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result_strobe (result_strobe),
    .cluster_size  (cluster_size),
    .largest_size  (largest_size),
    .merged        (merged)
);
`default_nettype wire

@@ dv/tb_union_find_percolation_tracker.sv @@
`timescale 1ns / 1ps
module tb_union_find_percolation_tracker;
    import ufpt_pkg::*;

    localparam logic [1:0] ACT_IDLE = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int RANDOM_ITEMS = 1850;

    typedef struct {
        logic [SIZE_W-1:0] cluster_size;
        logic [SIZE_W-1:0] component_count;
        logic [SIZE_W-1:0] largest_size;
        logic [NODE_W-1:0] largest_root;
        logic              merged;
        logic              node_done;
    } tracker_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        action = ACT_IDLE;
    logic [NODE_W-1:0] node = '0;
    logic [NODE_W-1:0] neighbor = '0;
    logic              link_active = 1'b0;
    logic              last_link = 1'b0;
    logic              result_strobe;
    logic [SIZE_W-1:0] cluster_size;
    logic [SIZE_W-1:0] component_count;
    logic [SIZE_W-1:0] largest_size;
    logic [NODE_W-1:0] largest_root;
    logic              merged;
    logic              node_done;

    // Shadow copy of the forest.
    logic              node_present [NODES];
    logic              node_is_root [NODES];
    logic [NODE_W-1:0] node_parent [NODES];
    logic [SIZE_W-1:0] tree_size [NODES];
    logic [NODE_W-1:0] current_root;
    logic [SIZE_W-1:0] cluster_count;
    logic [SIZE_W-1:0] top_size;
    logic [NODE_W-1:0] top_root;

    tracker_result_t pending_results[$];
    logic [NODE_W-1:0] present_nodes[$];
    int fails = 0;
    int cycles = 0;
    int burst_left = 0;
    int sent_items = 0;

    union_find_percolation_tracker DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .action(action),
        .node(node), .neighbor(neighbor), .link_active(link_active),
        .last_link(last_link), .result_strobe(result_strobe),
        .cluster_size(cluster_size), .component_count(component_count),
        .largest_size(largest_size), .largest_root(largest_root),
        .merged(merged), .node_done(node_done)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [NODE_W-1:0] find_cluster_root(logic [NODE_W-1:0] start_node);
        logic [NODE_W-1:0] r;
        logic [NODE_W-1:0] n;
        logic [NODE_W-1:0] nxt;
        int steps;
        r = start_node;
        steps = 0;
        while (!node_is_root[r] && steps < NODES)
        begin
            r = node_parent[r];
            steps++;
        end
        n = start_node;
        steps = 0;
        while (n != r && steps < NODES)
        begin
            nxt = node_parent[n];
            node_parent[n] = r;
            n = nxt;
            steps++;
        end
        return r;
    endfunction

    function automatic void note_largest(logic [NODE_W-1:0] root);
        if (tree_size[root] > top_size)
        begin
            top_size = tree_size[root];
            top_root = root;
        end
    endfunction

    function automatic void clear_forest();
        for (int i = 0; i < NODES; i++)
        begin
            node_present[i] = 1'b0;
            node_is_root[i] = 1'b0;
        end
        present_nodes.delete();
        current_root = '0;
        cluster_count = '0;
        top_size = '0;
        top_root = '0;
    endfunction

    function automatic tracker_result_t predict_percolation(logic [1:0] act,
            logic [NODE_W-1:0] n, logic [NODE_W-1:0] nb, logic active, logic last);
        tracker_result_t res;
        logic [NODE_W-1:0] s;
        logic [NODE_W-1:0] t;
        res = '{default: '0};
        res.node_done = last;
        if (act == ACT_CLEAR)
        begin
            clear_forest();
            res.node_done = 1'b0;
        end
        else if (act == ACT_ADD)
        begin
            if (node_present[n])
                current_root = find_cluster_root(n);
            else
            begin
                node_present[n] = 1'b1;
                node_is_root[n] = 1'b1;
                node_parent[n] = n;
                tree_size[n] = SIZE_W'(1);
                cluster_count++;
                current_root = n;
                present_nodes.push_back(n);
            end
            note_largest(current_root);
            res.cluster_size = tree_size[current_root];
        end
        else if (act == ACT_LINK)
        begin
            s = current_root;
            if (node_present[s] && node_is_root[s])
            begin
                if (active && node_present[nb])
                begin
                    t = find_cluster_root(nb);
                    if (t != s)
                    begin
                        // On equal sizes the neighbor's cluster hangs under the source.
                        if (tree_size[s] < tree_size[t])
                        begin
                            tree_size[t] += tree_size[s];
                            node_parent[s] = t;
                            node_is_root[s] = 1'b0;
                            current_root = t;
                        end
                        else
                        begin
                            tree_size[s] += tree_size[t];
                            node_parent[t] = s;
                            node_is_root[t] = 1'b0;
                        end
                        if (cluster_count > 0)
                            cluster_count--;
                        res.merged = 1'b1;
                    end
                end
                note_largest(current_root);
                res.cluster_size = tree_size[current_root];
            end
        end
        res.component_count = cluster_count;
        res.largest_size = top_size;
        res.largest_root = top_root;
        return res;
    endfunction

    // Drives one item from a falling edge and returns at the falling edge after
    // it was accepted, with start low again.
    task automatic send_item(logic [1:0] act, logic [NODE_W-1:0] n,
            logic [NODE_W-1:0] nb, logic active, logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                start = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        start = 1'b1;
        action = act;
        node = n;
        neighbor = nb;
        link_active = active;
        last_link = last;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(predict_percolation(act, n, nb, active, last));
        sent_items++;
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic check_field(string name, int expected, int actual);
        if (expected != actual)
        begin
            $error("%s expected %0d got %0d", name, expected, actual);
            fails++;
        end
    endtask

    always @(posedge clk)
    begin
        tracker_result_t want;
        if (rst_n && result_strobe)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no item outstanding");
                fails++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("cluster_size", want.cluster_size, cluster_size);
                check_field("component_count", want.component_count, component_count);
                check_field("largest_size", want.largest_size, largest_size);
                check_field("largest_root", want.largest_root, largest_root);
                check_field("merged", want.merged, merged);
                check_field("node_done", want.node_done, node_done);
            end
        end
    end

    function automatic logic [NODE_W-1:0] pick_neighbor();
        if (present_nodes.size() > 0 && $urandom_range(0, 9) != 0)
            return present_nodes[$urandom_range(0, present_nodes.size() - 1)];
        return NODE_W'($urandom);
    endfunction

    task automatic test_empty_and_noops();
        send_item(ACT_LINK, 10'd5, 10'd7, 1'b1, 1'b1);
        send_item(ACT_IDLE, 10'h3FF, 10'h3FF, 1'b1, 1'b1);
        send_item(ACT_CLEAR, 10'h3FF, 10'h3FF, 1'b1, 1'b1);
    endtask

    task automatic test_extremes_and_ties();
        send_item(ACT_ADD, 10'd0, 10'd0, 1'b0, 1'b1);
        send_item(ACT_ADD, 10'h3FF, 10'h3FF, 1'b1, 1'b0);
        send_item(ACT_LINK, 10'd0, 10'd0, 1'b1, 1'b1);        // tie, 0 joins 1023
        send_item(ACT_ADD, 10'd512, 10'd0, 1'b0, 1'b0);
        send_item(ACT_LINK, 10'd0, 10'd0, 1'b0, 1'b0);        // inactive link
        send_item(ACT_LINK, 10'd0, 10'd100, 1'b1, 1'b0);      // absent neighbor
        send_item(ACT_LINK, 10'd0, 10'd512, 1'b1, 1'b0);      // link to itself
        send_item(ACT_LINK, 10'd0, 10'd0, 1'b1, 1'b1);        // smaller source moves
        send_item(ACT_ADD, 10'd0, 10'd0, 1'b0, 1'b1);         // re-add present node
        send_item(ACT_LINK, 10'd0, 10'h3FF, 1'b1, 1'b1);      // same cluster
        send_item(ACT_IDLE, 10'd0, 10'd0, 1'b0, 1'b0);
        send_item(ACT_CLEAR, 10'd0, 10'd0, 1'b0, 1'b0);
        send_item(ACT_LINK, 10'd0, 10'd0, 1'b1, 1'b1);        // no source after clear
    endtask

    task automatic test_random_percolation();
        int base;
        int span;
        int links;
        int since_clear;
        logic [NODE_W-1:0] n;
        since_clear = 0;
        while (sent_items < RANDOM_ITEMS)
        begin
            if (since_clear > $urandom_range(150, 400))
            begin
                send_item(ACT_CLEAR, NODE_W'($urandom), NODE_W'($urandom),
                          1'($urandom), 1'($urandom));
                since_clear = 0;
            end
            // Mostly small windows so clusters grow large and chains get deep.
            span = ($urandom_range(0, 7) == 0) ? NODES : $urandom_range(8, 96);
            base = $urandom_range(0, NODES - span);
            repeat ($urandom_range(10, 60))
            begin
                if (sent_items >= RANDOM_ITEMS)
                    break;
                n = NODE_W'(base + $urandom_range(0, span - 1));
                links = $urandom_range(0, 4);
                send_item(ACT_ADD, n, NODE_W'($urandom), 1'($urandom), links == 0);
                for (int k = 0; k < links; k++)
                    send_item(ACT_LINK, NODE_W'($urandom), pick_neighbor(),
                              $urandom_range(0, 7) != 0, k == links - 1);
                if ($urandom_range(0, 19) == 0)
                    send_item(ACT_IDLE, NODE_W'($urandom), NODE_W'($urandom),
                              1'($urandom), 1'($urandom));
                since_clear += links + 1;
            end
        end
    endtask

    initial
    begin
        clear_forest();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_empty_and_noops();
        test_extremes_and_ties();
        test_random_percolation();
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fails == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
